// File: src/url_path_percent_escaper_assert.svh
// Assertion macros shared by the escaper RTL.
`ifndef URL_PATH_PERCENT_ESCAPER_ASSERT_SVH
`define URL_PATH_PERCENT_ESCAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/upe_pkg.sv
package upe_pkg;

	localparam int unsigned MaxOut = 7;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UD    = 8'h44;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LF    = 8'h66;

	// Bytes produced by one character handled from the idle mode.
	typedef struct packed {
		logic [1:0]      len;
		logic [2:0][7:0] b;
		logic            to_slash;
		logic            to_pct;
	} plain_t;

	// Result bytes of one transfer, in order from entry zero.
	typedef struct packed {
		logic [MaxOut-1:0][7:0] data;
		logic [2:0]             cnt;
	} enc_t;

	function automatic plain_t esc3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		plain_t p;
		p = '0;
		p.len = 2'd3;
		p.b[0] = a;
		p.b[1] = b;
		p.b[2] = c;
		return p;
	endfunction

	function automatic plain_t lit1(logic [7:0] a);
		plain_t p;
		p = '0;
		p.len = 2'd1;
		p.b[0] = a;
		return p;
	endfunction

	function automatic plain_t plain_enc(logic [7:0] c);
		plain_t p;
		p = lit1(c);
		case (c)
			CH_PLUS:  p = esc3(CH_PCT, CH_2, CH_UB);
			CH_SPACE: p = esc3(CH_PCT, CH_2, CH_0);
			CH_QUEST: p = esc3(CH_PCT, CH_3, CH_UF);
			CH_HASH:  p = esc3(CH_PCT, CH_2, CH_3);
			CH_AMP:   p = esc3(CH_PCT, CH_2, CH_6);
			CH_EQ:    p = esc3(CH_PCT, CH_3, CH_UD);
			CH_SLASH: p.to_slash = 1'b1;
			CH_PCT: begin
				p.len = 2'd0;
				p.to_pct = 1'b1;
			end
			default:  p = lit1(c);
		endcase
		return p;
	endfunction

	// True when a held percent sign, digit d and byte c form an escape kept as is.
	function automatic logic kept(logic [7:0] d, logic [7:0] c);
		logic k;
		k = 1'b0;
		if (d == CH_2) begin
			case (c) inside
				CH_UB, CH_LB, CH_UF, CH_LF, CH_0, CH_5, CH_3, CH_6: k = 1'b1;
				default: k = 1'b0;
			endcase
		end else if (d == CH_3) begin
			case (c) inside
				CH_UF, CH_LF, CH_UD, CH_LD: k = 1'b1;
				default: k = 1'b0;
			endcase
		end
		return k;
	endfunction

	function automatic enc_t enc_add(enc_t e, plain_t p);
		enc_t r;
		r = e;
		for (int i = 0; i < 3; i++) begin
			if (i < int'(p.len)) begin
				r.data[r.cnt] = p.b[i];
				r.cnt = r.cnt + 3'd1;
			end
		end
		return r;
	endfunction

endpackage

// File: src/url_path_percent_escaper.sv
// Channel   Dir  tdata                  tlast        tuser
// s_axis    in   [7:0] in_byte          final_byte   -
// m_axis    out  [7:0] out_byte         run_end      string_end
//
// A byte is taken into the input register and, once the result register is
// free, expanded into up to seven result bytes, which then leave one per cycle
// while m_axis_tready is high. The result count of an input transfer is 0 to 7
// (usually 1 or 3); a transfer with no result leaves the result register empty.
// Reset (arst_n low) empties both registers and returns the scanner to idle.
// A stall on m_axis holds the result register and then the input register.
`include "url_path_percent_escaper_assert.svh"

module url_path_percent_escaper
	import upe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // final_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // run_end
	output logic       m_axis_tuser    // [0] string_end
);

	// Scanner modes: idle, slash just sent, percent held, percent and digit held.
	typedef enum logic [1:0] {
		M_IDLE,
		M_SLASH,
		M_PCT,
		M_DIGIT
	} mode_t;

	function automatic mode_t mode_after(plain_t p);
		mode_t m;
		m = M_IDLE;
		if (p.to_slash) begin
			m = M_SLASH;
		end else if (p.to_pct) begin
			m = M_PCT;
		end
		return m;
	endfunction

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// Result register: the expanded bytes of one transfer and a read pointer.
	logic                   busy_s2;
	logic [MaxOut-1:0][7:0] data_s2;
	logic [2:0]             cnt_s2;
	logic [2:0]             idx_s2;
	logic                   fin_s2;

	// Scanner state.
	mode_t      mode_q;
	logic [7:0] held_q;

	mode_t      nxt_mode;
	logic [7:0] nxt_held;
	enc_t       enc;
	plain_t     p;

	logic last_out;
	logic s2_free;
	logic load;

	assign last_out = (idx_s2 == (cnt_s2 - 3'd1));
	// The result register can take new bytes when empty or when its last byte
	// leaves in this cycle.
	assign s2_free = !busy_s2 || (m_axis_tready && last_out);
	assign load = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	assign m_axis_tvalid = busy_s2;
	assign m_axis_tdata  = data_s2[idx_s2];
	assign m_axis_tlast  = last_out;
	assign m_axis_tuser  = last_out && fin_s2;

	// Expansion of the held byte against the current scanner mode.
	always_comb begin
		enc = '0;
		p = '0;
		nxt_mode = mode_q;
		nxt_held = held_q;
		unique case (mode_q)
			M_SLASH: begin
				if (byte_s1 == CH_SLASH) begin
					enc = enc_add(enc, esc3(CH_PCT, CH_2, CH_UF));
					nxt_mode = M_IDLE;
				end else begin
					p = plain_enc(byte_s1);
					enc = enc_add(enc, p);
					nxt_mode = mode_after(p);
				end
			end
			M_PCT: begin
				if (byte_s1 == CH_2 || byte_s1 == CH_3) begin
					nxt_held = byte_s1;
					nxt_mode = M_DIGIT;
				end else begin
					enc = enc_add(enc, esc3(CH_PCT, CH_2, CH_5));
					p = plain_enc(byte_s1);
					enc = enc_add(enc, p);
					nxt_mode = mode_after(p);
				end
			end
			M_DIGIT: begin
				if (kept(held_q, byte_s1)) begin
					enc = enc_add(enc, esc3(CH_PCT, held_q, byte_s1));
					nxt_mode = M_IDLE;
				end else begin
					// Broken escape: the percent sign is escaped and the digit and
					// the current byte are scanned as ordinary input.
					enc = enc_add(enc, esc3(CH_PCT, CH_2, CH_5));
					enc = enc_add(enc, plain_enc(held_q));
					p = plain_enc(byte_s1);
					enc = enc_add(enc, p);
					nxt_mode = mode_after(p);
				end
			end
			M_IDLE: begin
				p = plain_enc(byte_s1);
				enc = enc_add(enc, p);
				nxt_mode = mode_after(p);
			end
		endcase
		// At the end of the string, flush any held percent sign and digit.
		if (fin_s1) begin
			if (nxt_mode == M_PCT) begin
				enc = enc_add(enc, esc3(CH_PCT, CH_2, CH_5));
			end else if (nxt_mode == M_DIGIT) begin
				enc = enc_add(enc, esc3(CH_PCT, CH_2, CH_5));
				enc = enc_add(enc, lit1(nxt_held));
			end
			nxt_mode = M_IDLE;
			nxt_held = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			fin_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			busy_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (load) begin
			mode_q <= nxt_mode;
			held_q <= nxt_held;
			busy_s2 <= (enc.cnt != 3'd0);
			idx_s2 <= '0;
		end else if (busy_s2 && m_axis_tready) begin
			if (last_out) begin
				busy_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= enc.data;
			cnt_s2 <= enc.cnt;
			fin_s2 <= fin_s1;
		end
	end

	`UPE_ASSERT_IMPLY(a_ptr_in_range, clk, arst_n, busy_s2, (cnt_s2 != 3'd0) && (idx_s2 < cnt_s2), "result pointer outside the stored bytes")
	`UPE_ASSERT_NEXT(a_stall_holds_ptr, clk, arst_n, busy_s2 && !m_axis_tready, busy_s2 && $stable(idx_s2), "result pointer moved during an output stall")
	`UPE_ASSERT_IMPLY(a_digit_valid, clk, arst_n, mode_q == M_DIGIT, (held_q == CH_2) || (held_q == CH_3), "held digit is not two or three")
	`UPE_ASSERT_NEXT(a_final_idle, clk, arst_n, load && fin_s1, (mode_q == M_IDLE) && (held_q == 8'h00) && busy_s2, "scanner not idle after the final byte")
	`UPE_ASSERT_IMPLY(a_ready_blocked, clk, arst_n, valid_s1 && busy_s2 && !last_out, !s_axis_tready, "input taken while the result register still drains")

endmodule

// File: tb/testbench.sv
// Self-checking bench for the URL resource path escaper.
//
// Path strings go in on the slave stream one byte per transfer, with tlast on
// the final byte of each string. A behavioral escaper inside the bench works
// out the escaped bytes of every accepted input transfer. Each output
// transfer is checked against the oldest expected byte, field by field.
//
// The stimulus starts with a short directed section. It covers the zero and
// all-ones bytes, every character that gets escaped, a run of three slashes,
// kept escapes in both letter cases, broken escapes, and the flush of a held
// percent sign or digit at the end of a string. After that come random
// paths. They are built mostly from well-formed tokens (kept escapes, doubled
// slashes, reserved characters) mixed with raw random bytes and broken
// escapes.
//
// The run has three idle phases. In the first, the sender rarely pauses and
// the receiver often does. In the second it is the other way round. In the
// third neither side pauses. That last phase opens with a long receiver
// stall so the block backs up and deasserts s_axis_tready.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import upe_pkg::*;

	localparam int unsigned PathItems    = 410;
	localparam int unsigned Phase1Start  = 160;
	localparam int unsigned Phase2Start  = 290;
	localparam int unsigned StallCycles  = 400;
	localparam int unsigned IdleLimit    = 5000;
	localparam int unsigned DrainCycles  = 40;
	localparam int unsigned MaxPrinted   = 50;

	// These are the bytes that may follow a held '2' or '3' for the escape
	// to be copied unchanged. They are packed eight bits per entry.
	localparam logic [8*8-1:0] KeepAfter2 =
		{CH_UB, CH_LB, CH_UF, CH_LF, CH_0, CH_5, CH_3, CH_6};
	localparam logic [4*8-1:0] KeepAfter3 = {CH_UF, CH_LF, CH_UD, CH_LD};
	localparam logic [6*8-1:0] Reserved   =
		{CH_PLUS, CH_SPACE, CH_QUEST, CH_HASH, CH_AMP, CH_EQ};

	// These are the lookahead states of the escaper.
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_SLASH,
		SCAN_PCT,
		SCAN_DIGIT
	} scan_mode_t;

	// This is one path byte waiting to be sent, tagged with its idle phase.
	typedef struct {
		logic [7:0] path_byte;
		logic       last_byte;
		logic [1:0] phase;
	} path_item_t;

	// This is one expected output transfer.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       string_end;
	} esc_byte_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	url_path_percent_escaper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	path_item_t  path_q[$];
	logic [7:0]  path_buf[$];
	esc_byte_t   escaped_q[$];
	logic [7:0]  step_bytes[$];

	scan_mode_t  esc_mode   = SCAN_IDLE;
	logic [7:0]  esc_held   = 8'h00;
	int unsigned n_queued   = 0;
	int unsigned err_count  = 0;
	int unsigned idle_count = 0;
	int unsigned hold_left  = 0;
	logic        hold_done  = 1'b0;
	logic        started    = 1'b0;
	logic        in_xfer    = 1'b0;
	logic [1:0]  tx_phase   = 2'd0;
	logic [1:0]  rx_phase   = 2'd0;

	// ------------------------------------------------------------------
	// Behavioral escaper
	// ------------------------------------------------------------------

	function automatic logic pair_is_kept(input logic [7:0] digit, input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		if (digit == CH_2) begin
			for (int i = 0; i < 8; i++)
				if (KeepAfter2[8*i +: 8] == c)
					hit = 1'b1;
		end else if (digit == CH_3) begin
			for (int i = 0; i < 4; i++)
				if (KeepAfter3[8*i +: 8] == c)
					hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic void emit3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		step_bytes.push_back(a);
		step_bytes.push_back(b);
		step_bytes.push_back(c);
	endfunction

	// This handles a byte seen with no lookahead pending. A slash or a
	// percent sign opens new lookahead.
	function automatic void escape_plain(input logic [7:0] c);
		case (c)
			CH_PLUS:  emit3(CH_PCT, CH_2, CH_UB);
			CH_SPACE: emit3(CH_PCT, CH_2, CH_0);
			CH_QUEST: emit3(CH_PCT, CH_3, CH_UF);
			CH_HASH:  emit3(CH_PCT, CH_2, CH_3);
			CH_AMP:   emit3(CH_PCT, CH_2, CH_6);
			CH_EQ:    emit3(CH_PCT, CH_3, CH_UD);
			CH_SLASH: begin
				step_bytes.push_back(CH_SLASH);
				esc_mode = SCAN_SLASH;
			end
			CH_PCT:   esc_mode = SCAN_PCT;
			default:  step_bytes.push_back(c);
		endcase
	endfunction

	// This advances the escaper by one accepted input byte and queues the
	// output transfers that the byte causes.
	function automatic void predict_escape(input logic [7:0] c, input logic fin);
		esc_byte_t r;
		int        last;
		step_bytes = {};
		case (esc_mode)
			SCAN_SLASH: begin
				esc_mode = SCAN_IDLE;
				if (c == CH_SLASH)
					emit3(CH_PCT, CH_2, CH_UF);
				else
					escape_plain(c);
			end
			SCAN_PCT: begin
				if (c == CH_2 || c == CH_3) begin
					esc_held = c;
					esc_mode = SCAN_DIGIT;
				end else begin
					esc_mode = SCAN_IDLE;
					emit3(CH_PCT, CH_2, CH_5);
					escape_plain(c);
				end
			end
			SCAN_DIGIT: begin
				esc_mode = SCAN_IDLE;
				if (pair_is_kept(esc_held, c)) begin
					emit3(CH_PCT, esc_held, c);
				end else begin
					// The percent sign was not part of an escape. The held
					// digit and the new byte are then handled as plain bytes.
					emit3(CH_PCT, CH_2, CH_5);
					escape_plain(esc_held);
					escape_plain(c);
				end
			end
			default: begin
				esc_mode = SCAN_IDLE;
				escape_plain(c);
			end
		endcase

		// At the end of a string, held lookahead is flushed. A pending slash
		// needs nothing.
		if (fin) begin
			if (esc_mode == SCAN_PCT) begin
				emit3(CH_PCT, CH_2, CH_5);
			end else if (esc_mode == SCAN_DIGIT) begin
				emit3(CH_PCT, CH_2, CH_5);
				step_bytes.push_back(esc_held);
			end
			esc_mode = SCAN_IDLE;
			esc_held = 8'h00;
		end

		last = step_bytes.size() - 1;
		foreach (step_bytes[i]) begin
			r.out_byte   = step_bytes[i];
			r.run_end    = (i == last);
			r.string_end = fin && (i == last);
			escaped_q.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			path_buf.push_back(s[i]);
	endfunction

	// This moves the path being built into the send queue. Its last byte is
	// marked as the end of the string.
	function automatic void flush_path();
		path_item_t it;
		foreach (path_buf[i]) begin
			it.path_byte = path_buf[i];
			it.last_byte = (i == path_buf.size() - 1);
			it.phase     = (n_queued < Phase1Start) ? 2'd0 :
			               (n_queued < Phase2Start) ? 2'd1 : 2'd2;
			path_q.push_back(it);
			n_queued++;
		end
		path_buf = {};
	endfunction

	function automatic logic [7:0] pick_digit();
		return $urandom_range(0, 1) ? CH_2 : CH_3;
	endfunction

	// This appends one token of a random path. Most tokens are well formed.
	// The rest are raw bytes and broken escapes.
	function automatic void add_token();
		logic [7:0] digit;
		case ($urandom_range(0, 11))
			0: path_buf.push_back(8'($urandom_range(0, 255)));
			1, 2, 3: path_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
			4: path_buf.push_back(Reserved[8*$urandom_range(0, 5) +: 8]);
			5: path_buf.push_back(CH_SLASH);
			6: begin
				repeat ($urandom_range(2, 3))
					path_buf.push_back(CH_SLASH);
			end
			7: begin
				digit = pick_digit();
				path_buf.push_back(CH_PCT);
				path_buf.push_back(digit);
				if (digit == CH_2)
					path_buf.push_back(KeepAfter2[8*$urandom_range(0, 7) +: 8]);
				else
					path_buf.push_back(KeepAfter3[8*$urandom_range(0, 3) +: 8]);
			end
			8: begin
				path_buf.push_back(CH_PCT);
				path_buf.push_back(pick_digit());
				path_buf.push_back(8'($urandom_range(0, 255)));
			end
			9: begin
				path_buf.push_back(CH_PCT);
				path_buf.push_back(8'($urandom_range(0, 255)));
			end
			10: path_buf.push_back(KeepAfter2[8*$urandom_range(0, 7) +: 8]);
			default: begin
				path_buf.push_back(CH_PCT);
				path_buf.push_back(CH_PCT);
			end
		endcase
	endfunction

	function automatic void add_random_path();
		repeat ($urandom_range(1, 6))
			add_token();
		// Some strings end with a held percent sign or digit, so the flush
		// at the last byte gets exercised.
		case ($urandom_range(0, 7))
			0: path_buf.push_back(CH_PCT);
			1: begin
				path_buf.push_back(CH_PCT);
				path_buf.push_back(pick_digit());
			end
			default: ;
		endcase
		flush_path();
	endfunction

	function automatic int unsigned send_idle_pct(input logic [1:0] phase);
		return (phase == 2'd0) ? 9 : (phase == 2'd1) ? 75 : 0;
	endfunction

	function automatic int unsigned recv_idle_pct(input logic [1:0] phase);
		return (phase == 2'd0) ? 75 : (phase == 2'd1) ? 9 : 0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MaxPrinted)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and run control
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;

		// The directed section covers the extreme bytes, every reserved
		// character, three slashes in a row, and kept escapes in both letter
		// cases.
		path_buf.push_back(8'h00);
		path_buf.push_back(8'hFF);
		add_text("+ ?#&=");
		flush_path();
		add_text("///a");
		flush_path();
		add_text("%2b%3D");
		flush_path();
		// These strings hold a percent sign followed by another percent sign,
		// a digit and a byte that does not complete an escape, then end
		// while a percent sign and digit, or a lone percent sign, is still
		// held. A lone slash ends the last one.
		add_text("%%2Z");
		flush_path();
		add_text("%2");
		flush_path();
		add_text("%");
		flush_path();
		add_text("/");
		flush_path();

		while (n_queued < PathItems)
			add_random_path();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		started = 1'b1;

		// The run waits until every byte is sent and every expected byte has
		// come back. It then lets the block sit for a while to catch any
		// stray output.
		while (path_q.size() != 0 || s_axis_tvalid || escaped_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: the slave side, updated at the falling edge.
	// ------------------------------------------------------------------

	always @(negedge clk) begin : drive_proc
		path_item_t it;
		logic       v_next;
		logic [7:0] d_next;
		logic       l_next;
		v_next = s_axis_tvalid;
		d_next = s_axis_tdata;
		l_next = s_axis_tlast;
		// A new byte is offered only when nothing is pending, or when the
		// last rising edge took the byte that was offered.
		if (started && (!s_axis_tvalid || in_xfer)) begin
			v_next = 1'b0;
			if (path_q.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct(path_q[0].phase)) begin
				it       = path_q.pop_front();
				v_next   = 1'b1;
				d_next   = it.path_byte;
				l_next   = it.last_byte;
				tx_phase = it.phase;
			end
		end
		s_axis_tvalid <= v_next;
		s_axis_tdata  <= d_next;
		s_axis_tlast  <= l_next;
	end

	// ------------------------------------------------------------------
	// Receiver: the master-side ready signal, updated at the falling edge.
	// ------------------------------------------------------------------

	always @(negedge clk) begin : accept_proc
		logic r_next;
		r_next = 1'b0;
		if (started) begin
			if (hold_left != 0) begin
				hold_left--;
			end else if (rx_phase == 2'd2 && !hold_done) begin
				// When the no-idle phase begins, the output stalls for a long
				// stretch while the sender keeps offering bytes. This fills
				// the block until it stops taking input.
				hold_done = 1'b1;
				hold_left = StallCycles - 1;
			end else begin
				r_next = ($urandom_range(0, 99) >= recv_idle_pct(rx_phase));
			end
		end
		m_axis_tready <= r_next;
	end

	// ------------------------------------------------------------------
	// Monitor: both sides are sampled at the rising edge.
	// ------------------------------------------------------------------

	always @(posedge clk) begin : monitor_proc
		esc_byte_t want;
		in_xfer = s_axis_tvalid && s_axis_tready;
		if (in_xfer) begin
			rx_phase = tx_phase;
			predict_escape(s_axis_tdata, s_axis_tlast);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (escaped_q.size() == 0) begin
				report_mismatch("output transfer with nothing expected", m_axis_tdata, 0);
			end else begin
				want = escaped_q.pop_front();
				if (m_axis_tdata !== want.out_byte)
					report_mismatch("out_byte", m_axis_tdata, want.out_byte);
				if (m_axis_tlast !== want.run_end)
					report_mismatch("run_end", m_axis_tlast, want.run_end);
				if (m_axis_tuser !== want.string_end)
					report_mismatch("string_end", m_axis_tuser, want.string_end);
			end
		end
	end

	// The watchdog ends a run that has stopped making progress. Every cycle
	// with no transfer on either side counts toward the limit.
	always @(posedge clk) begin
		if (started) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= IdleLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

// File: url_path_percent_escaper.f
+incdir+src
src/upe_pkg.sv
src/url_path_percent_escaper.sv
tb/testbench.sv
